@@ rtl/mbd_pkg.sv @@
package mbd_pkg;

    localparam int TIME_W     = 32;
    localparam int LEVELS_W   = 8;
    localparam int KIND_W     = 2;
    localparam int IDX_OUT_W  = 3;
    localparam int MASK_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TIME   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_TIME = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW      = 2'd2;

    localparam logic [CFG_DATA_W-1:0] DEBOUNCE_TIME_RST   = 16'd20;
    localparam logic [CFG_DATA_W-1:0] LONG_PRESS_TIME_RST = 16'd800;

    typedef enum logic [KIND_W-1:0] {
        EV_NONE    = 2'd0,
        EV_PRESS   = 2'd1,
        EV_LONG    = 2'd2,
        EV_RELEASE = 2'd3
    } t_event;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DEB  = 4'b0010,
        ST_LONG = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

endpackage

@@ rtl/mbd_intf.sv @@
interface mbd_in_if import mbd_pkg::*;;
    logic                valid;
    logic                ready;
    logic [TIME_W-1:0]   now_ms;
    logic [LEVELS_W-1:0] raw_levels;

    modport source (output valid, output now_ms, output raw_levels, input ready);
    modport sink   (input valid, input now_ms, input raw_levels, output ready);
endinterface

interface mbd_out_if import mbd_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    event_kind;
    logic [IDX_OUT_W-1:0] button_index;
    logic [MASK_W-1:0]    pressed_mask;

    modport source (output valid, output event_kind, output button_index,
                    output pressed_mask, input ready);
    modport sink   (input valid, input event_kind, input button_index,
                    input pressed_mask, output ready);
endinterface

@@ rtl/multi_button_debounce_longpress.sv @@
// Channel   Direction  Payload                                   Handshake
// i_in_if   in         now_ms[31:0], raw_levels[7:0]             valid / ready
// o_out_if  out        event_kind[1:0], button_index[2:0],       valid / ready
//                      pressed_mask[7:0]
// cfg       in         i_cfg_idx[1:0], i_cfg_data[15:0]          i_cfg_we, no wait
//
// A poll is worked off button by button on the single 32-bit
// subtract-and-compare unit, which each button visits twice: once for the
// debounce window and once for the long-press window. A new poll is taken
// only after the last one has gone to the output register.
// Reset is synchronous and active low; it restores the registers to their
// documented defaults and clears all per-button state and the output register.
// A result waits in the output register while the sink stalls; the next poll
// is still taken meanwhile and only its final hand-off waits for the slot.
module multi_button_debounce_longpress import mbd_pkg::*; #(
    parameter int NUM_BUTTONS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    mbd_in_if.sink                i_in_if,
    mbd_out_if.source             o_out_if
);

    localparam int BTN_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam logic [BTN_W-1:0] LAST_BTN = BTN_W'(NUM_BUTTONS - 1);

    // Sequencer and captured poll.
    t_state              r_state;
    logic [BTN_W-1:0]    r_btn;
    logic [TIME_W-1:0]   r_now;
    logic [LEVELS_W-1:0] r_levels;
    logic                r_found;
    t_event              r_kind;
    logic [BTN_W-1:0]    r_idx;

    // Configuration registers.
    logic [CFG_DATA_W-1:0] r_debounce_time;
    logic [CFG_DATA_W-1:0] r_long_time;
    logic                  r_active_low;

    // Per-button state. The time stamps are read only at the button under visit.
    logic [NUM_BUTTONS-1:0] r_last_raw;
    logic [TIME_W-1:0]      r_change_time [NUM_BUTTONS];
    logic [TIME_W-1:0]      r_press_time  [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] r_deb;
    logic [NUM_BUTTONS-1:0] r_long_fired;
    logic [NUM_BUTTONS-1:0] r_pend_press;
    logic [NUM_BUTTONS-1:0] r_pend_long;
    logic [NUM_BUTTONS-1:0] r_pend_rel;

    // Output register.
    logic                 r_out_valid;
    t_event               r_out_kind;
    logic [IDX_OUT_W-1:0] r_out_idx;
    logic [MASK_W-1:0]    r_out_mask;

    logic [NUM_BUTTONS-1:0] w_raw_all;
    logic                   w_raw;
    logic                   w_chg;
    logic                   w_target;
    logic [TIME_W-1:0]      w_sub_b;
    logic [CFG_DATA_W-1:0]  w_thr;
    logic [TIME_W-1:0]      w_diff;
    logic                   w_reached;
    logic                   w_fire_long;
    logic                   w_pl;
    logic [BTN_W+2:0]       w_idx_ext;
    logic [MASK_W-1:0]      w_mask;

    // Buttons without an input pin always read as released under the current
    // polarity.
    genvar gi;
    generate
        for (gi = 0; gi < NUM_BUTTONS; gi++) begin : g_raw
            if (gi < LEVELS_W) begin : g_pin
                assign w_raw_all[gi] = r_levels[gi];
            end else begin : g_nopin
                assign w_raw_all[gi] = r_active_low;
            end
        end
        for (gi = 0; gi < MASK_W; gi++) begin : g_mask
            if (gi < NUM_BUTTONS) begin : g_used
                assign w_mask[gi] = r_deb[gi];
            end else begin : g_unused
                assign w_mask[gi] = 1'b0;
            end
        end
    endgenerate

    assign w_raw    = w_raw_all[r_btn];
    assign w_chg    = (w_raw != r_last_raw[r_btn]);
    assign w_target = w_raw ^ r_active_low;

    // The shared unit: a wrapping 32-bit subtract followed by a compare against
    // the window selected for the current phase. A raw change restarts the
    // debounce window at this poll's time.
    always_comb begin
        case (r_state)
            ST_DEB: begin
                w_sub_b = w_chg ? r_now : r_change_time[r_btn];
                w_thr   = r_debounce_time;
            end
            default: begin
                w_sub_b = r_press_time[r_btn];
                w_thr   = r_long_time;
            end
        endcase
    end

    assign w_diff    = r_now - w_sub_b;
    assign w_reached = (w_diff >= TIME_W'(w_thr));

    assign w_fire_long = r_deb[r_btn] && !r_long_fired[r_btn] && w_reached;
    assign w_pl        = r_pend_long[r_btn] || w_fire_long;

    assign w_idx_ext = (BTN_W + 3)'(r_idx);

    assign i_in_if.ready         = (r_state == ST_IDLE);
    assign o_out_if.valid        = r_out_valid;
    assign o_out_if.event_kind   = r_out_kind;
    assign o_out_if.button_index = r_out_idx;
    assign o_out_if.pressed_mask = r_out_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_btn           <= '0;
            r_found         <= 1'b0;
            r_kind          <= EV_NONE;
            r_idx           <= '0;
            r_debounce_time <= DEBOUNCE_TIME_RST;
            r_long_time     <= LONG_PRESS_TIME_RST;
            r_active_low    <= 1'b1;
            r_last_raw      <= '1;
            r_deb           <= '0;
            r_long_fired    <= '0;
            r_pend_press    <= '0;
            r_pend_long     <= '0;
            r_pend_rel      <= '0;
            r_out_valid     <= 1'b0;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                r_change_time[i] <= '0;
                r_press_time[i]  <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DEBOUNCE_TIME:   r_debounce_time <= i_cfg_data;
                    CFG_LONG_PRESS_TIME: r_long_time     <= i_cfg_data;
                    CFG_ACTIVE_LOW:      r_active_low    <= i_cfg_data[0];
                    default: ;
                endcase
            end

            if (o_out_if.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (i_in_if.valid) begin
                        r_now    <= i_in_if.now_ms;
                        r_levels <= i_in_if.raw_levels;
                        r_btn    <= '0;
                        r_found  <= 1'b0;
                        r_kind   <= EV_NONE;
                        r_idx    <= '0;
                        r_state  <= ST_DEB;
                    end
                end
                ST_DEB: begin
                    if (w_chg) begin
                        r_last_raw[r_btn]    <= w_raw;
                        r_change_time[r_btn] <= r_now;
                    end
                    if (w_reached && (w_target != r_deb[r_btn])) begin
                        r_deb[r_btn] <= w_target;
                        if (w_target) begin
                            r_press_time[r_btn] <= r_now;
                            r_long_fired[r_btn] <= 1'b0;
                            r_pend_press[r_btn] <= 1'b1;
                        end else begin
                            r_pend_rel[r_btn] <= 1'b1;
                        end
                    end
                    r_state <= ST_LONG;
                end
                ST_LONG: begin
                    if (w_fire_long) begin
                        r_long_fired[r_btn] <= 1'b1;
                        r_pend_long[r_btn]  <= 1'b1;
                    end
                    // This button's flags are final now, so the lowest button
                    // with anything pending is picked during the same pass.
                    if (!r_found) begin
                        if (r_pend_press[r_btn]) begin
                            r_pend_press[r_btn] <= 1'b0;
                            r_kind  <= EV_PRESS;
                            r_idx   <= r_btn;
                            r_found <= 1'b1;
                        end else if (w_pl) begin
                            r_pend_long[r_btn] <= 1'b0;
                            r_kind  <= EV_LONG;
                            r_idx   <= r_btn;
                            r_found <= 1'b1;
                        end else if (r_pend_rel[r_btn]) begin
                            r_pend_rel[r_btn] <= 1'b0;
                            r_kind  <= EV_RELEASE;
                            r_idx   <= r_btn;
                            r_found <= 1'b1;
                        end
                    end
                    if (r_btn == LAST_BTN) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_btn   <= r_btn + 1'b1;
                        r_state <= ST_DEB;
                    end
                end
                ST_DONE: begin
                    if (!r_out_valid || o_out_if.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_kind  <= r_kind;
                        r_out_idx   <= w_idx_ext[IDX_OUT_W-1:0];
                        r_out_mask  <= w_mask;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/mbd_checker.sv @@
module mbd_checker import mbd_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_ready,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input logic [KIND_W-1:0]    i_event_kind,
    input logic [IDX_OUT_W-1:0] i_button_index,
    input logic [MASK_W-1:0]    i_pressed_mask
);

    // Reset empties the output register.
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // A poll without an event reports button zero.
    a_none_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_event_kind == EV_NONE)) |-> (i_button_index == '0))
        else $error("nonzero button index without event");

    // The block is busy right after it takes a poll.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("ready directly after a transaction");

    // A new result is loaded only by the final step of a poll, while the input is busy.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result appeared without a poll in progress");

    // A stalled result holds.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_event_kind) && $stable(i_button_index)
             && $stable(i_pressed_mask)))
        else $error("stalled result changed");

endmodule

bind multi_button_debounce_longpress mbd_checker u_mbd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_if.valid),
    .i_in_ready     (i_in_if.ready),
    .i_out_valid    (o_out_if.valid),
    .i_out_ready    (o_out_if.ready),
    .i_event_kind   (o_out_if.event_kind),
    .i_button_index (o_out_if.button_index),
    .i_pressed_mask (o_out_if.pressed_mask)
);

@@ verif/multi_button_debounce_longpress_tb.sv @@
`timescale 1ns / 100ps

module multi_button_debounce_longpress_tb;
    import mbd_pkg::*;

    localparam int NUM_BTN      = 8;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_POLLS  = 60;
    // A long receiver hold-off lets the block fill its output slot and stall its input.
    localparam int HOLD_CYCLES  = 300;
    // Once every result is out the block is idle; the drain then lets it settle.
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 60;
    // The slowest legal stretch without any transaction is the hold-off above plus one poll.
    localparam int IDLE_LIMIT    = 4000;

    // Index 3 has no register behind it; writes to it must leave everything unchanged.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    // One result of a poll: the event it pops and the debounced mask after it.
    typedef struct packed {
        t_event               kind;
        logic [IDX_OUT_W-1:0] button;
        logic [MASK_W-1:0]    mask;
    } t_button_event;

    // Keeps its own copy of the per-button debounce state, works out the result of
    // every accepted poll and checks the results in the order they come out.
    class debounce_scoreboard;
        logic [CFG_DATA_W-1:0] debounce_ms;
        logic [CFG_DATA_W-1:0] long_press_ms;
        logic                  active_low;
        logic [NUM_BTN-1:0]    last_raw;
        logic [NUM_BTN-1:0]    debounced;
        logic [NUM_BTN-1:0]    long_fired;
        logic [NUM_BTN-1:0]    want_press;
        logic [NUM_BTN-1:0]    want_long;
        logic [NUM_BTN-1:0]    want_release;
        logic [TIME_W-1:0]     change_ms [NUM_BTN];
        logic [TIME_W-1:0]     press_ms [NUM_BTN];
        t_button_event         expected_events [$];
        int                    mismatches;

        function new();
            mismatches    = 0;
            debounce_ms   = DEBOUNCE_TIME_RST;
            long_press_ms = LONG_PRESS_TIME_RST;
            active_low    = 1'b1;
            last_raw      = '1;
            debounced     = '0;
            long_fired    = '0;
            want_press    = '0;
            want_long     = '0;
            want_release  = '0;
            for (int b = 0; b < NUM_BTN; b++) begin
                change_ms[b] = '0;
                press_ms[b]  = '0;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_DEBOUNCE_TIME:   debounce_ms   = data;
                CFG_LONG_PRESS_TIME: long_press_ms = data;
                CFG_ACTIVE_LOW:      active_low    = data[0];
                default: ;
            endcase
        endfunction

        function void note_poll(logic [TIME_W-1:0] now, logic [LEVELS_W-1:0] levels);
            t_button_event     ev;
            logic [TIME_W-1:0] age;
            logic              target;
            int                b;
            for (b = 0; b < NUM_BTN; b++) begin
                if (levels[b] != last_raw[b]) begin
                    last_raw[b]  = levels[b];
                    change_ms[b] = now;
                end
                age    = now - change_ms[b];
                target = active_low ? ~last_raw[b] : last_raw[b];
                if (age >= TIME_W'(debounce_ms) && target != debounced[b]) begin
                    debounced[b] = target;
                    if (target) begin
                        press_ms[b]   = now;
                        long_fired[b] = 1'b0;
                        want_press[b] = 1'b1;
                    end else begin
                        want_release[b] = 1'b1;
                    end
                end
                age = now - press_ms[b];
                if (debounced[b] && !long_fired[b] && age >= TIME_W'(long_press_ms)) begin
                    long_fired[b] = 1'b1;
                    want_long[b]  = 1'b1;
                end
            end
            ev.kind   = EV_NONE;
            ev.button = '0;
            for (b = 0; b < NUM_BTN && ev.kind == EV_NONE; b++) begin
                if (want_press[b]) begin
                    want_press[b] = 1'b0;
                    ev.kind = EV_PRESS;
                end else if (want_long[b]) begin
                    want_long[b] = 1'b0;
                    ev.kind = EV_LONG;
                end else if (want_release[b]) begin
                    want_release[b] = 1'b0;
                    ev.kind = EV_RELEASE;
                end
                if (ev.kind != EV_NONE) begin
                    ev.button = IDX_OUT_W'(b);
                end
            end
            ev.mask = debounced;
            expected_events.push_back(ev);
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%t ERROR: %s", $realtime, msg);
            end
        endfunction

        function void check_result(logic [KIND_W-1:0] kind, logic [IDX_OUT_W-1:0] button,
                                   logic [MASK_W-1:0] mask);
            t_button_event want;
            if (expected_events.size() == 0) begin
                flag($sformatf("result with nothing expected: kind %0d button %0d mask %02h",
                               kind, button, mask));
                return;
            end
            want = expected_events.pop_front();
            if (kind !== want.kind || button !== want.button || mask !== want.mask) begin
                flag($sformatf("expected kind %0d button %0d mask %02h, got %0d %0d %02h",
                               want.kind, want.button, want.mask, kind, button, mask));
            end
        endfunction

        function int pending();
            return expected_events.size();
        endfunction

        function void flag_leftovers();
            while (expected_events.size() != 0) begin
                void'(expected_events.pop_front());
                flag("expected result never arrived");
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    mbd_in_if  in_if ();
    mbd_out_if out_if ();

    multi_button_debounce_longpress DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_if    (in_if.sink),
        .o_out_if   (out_if.source)
    );

    always #10 i_clk = ~i_clk;

    debounce_scoreboard events_sb;

    // When quiet is set, neither the sender nor the receiver inserts idle cycles.
    bit                quiet     = 1'b0;
    // A request from the stimulus to the receiver for one long hold-off.
    bit                hold_req  = 1'b0;
    int                idle_cycles = 0;
    logic [TIME_W-1:0] clock_ms;
    logic [NUM_BTN-1:0] held_level;

    // Both channels are sampled at the rising edge, before any of this edge's
    // nonblocking updates land. The result is checked before the poll of the same
    // edge is noted; a poll can never produce its own result at the edge it is accepted.
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            events_sb.check_result(out_if.event_kind, out_if.button_index, out_if.pressed_mask);
        end
        if (i_rst_n && in_if.valid && in_if.ready) begin
            events_sb.note_poll(in_if.now_ms, in_if.raw_levels);
        end
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
    end

    // The watchdog ends the run when no transaction happens for too long.
    initial begin : watchdog
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("*** FAILED ***");
        $finish;
    end

    // The receiver stalls in random bursts of random length, and once for a long
    // hold-off on request. The remaining stall is counted down here, so ready gets
    // exactly one assignment per edge.
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
            end else if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 18);
            end
            out_if.ready <= (stall_left == 0);
        end
    end

    // Offers one poll and returns at the edge where it is accepted. An optional gap
    // lowers valid first; without a gap valid stays high from the previous poll.
    task automatic offer_poll(input logic [TIME_W-1:0] now, input logic [LEVELS_W-1:0] levels);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.now_ms     <= now;
        in_if.raw_levels <= levels;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
    endtask

    // Stops offering polls and waits until every expected result has come out.
    task automatic drain();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (events_sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write enable stays high across back-to-back writes and is lowered by the caller.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        events_sb.write_reg(idx, data);
    endtask

    // Writes all three registers. The polarity write carries random upper bits, which
    // the block must drop, and sometimes a write to the unused index follows.
    task automatic set_config(input logic [CFG_DATA_W-1:0] deb, input logic [CFG_DATA_W-1:0] lp,
                              input logic pol);
        write_reg(CFG_DEBOUNCE_TIME, deb);
        write_reg(CFG_LONG_PRESS_TIME, lp);
        write_reg(CFG_ACTIVE_LOW, {15'($urandom), pol});
        if ($urandom_range(0, 1) == 1) begin
            write_reg(CFG_UNUSED_IDX, CFG_DATA_W'($urandom));
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // A well-formed poll is the held level of each button with occasional contact bounce
    // on one pin, or now and then random levels on all pins. Time mostly advances a few
    // milliseconds, sometimes far enough to pass the largest windows, and at times jumps anywhere so that it wraps.
    task automatic random_poll();
        logic [LEVELS_W-1:0] levels;
        int                  r;
        r = $urandom_range(0, 99);
        if (r < 3) begin
            clock_ms = clock_ms + TIME_W'($urandom);
        end else if (r < 8) begin
            clock_ms = clock_ms + TIME_W'($urandom_range(60000, 70000));
        end else begin
            clock_ms = clock_ms + TIME_W'($urandom_range(0, 12));
        end
        for (int b = 0; b < NUM_BTN; b++) begin
            if ($urandom_range(0, 19) == 0) begin
                held_level[b] = ~held_level[b];
            end
        end
        levels = held_level;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            levels = LEVELS_W'($urandom);
        end else if (r < 30) begin
            levels[$urandom_range(0, NUM_BTN - 1)] ^= 1'b1;
        end
        offer_poll(clock_ms, levels);
    endtask

    initial begin : stimulus
        int p;
        int n;
        events_sb        = new();
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_idx        <= CFG_DEBOUNCE_TIME;
        i_cfg_data       <= '0;
        in_if.valid      <= 1'b0;
        in_if.now_ms     <= '0;
        in_if.raw_levels <= '0;
        held_level       = '1;
        clock_ms         = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under the reset settings: a bounce-free press of button 0,
        // its long press 800 ms after the press and its release, then all buttons pressed across
        // the wrap of the millisecond counter so that eight presses queue up.
        offer_poll(32'd0, 8'hFF);
        offer_poll(32'd10, 8'hFE);
        offer_poll(32'd30, 8'hFE);
        offer_poll(32'd40, 8'hFE);
        offer_poll(32'd830, 8'hFE);
        offer_poll(32'd840, 8'hFF);
        offer_poll(32'd860, 8'hFF);
        offer_poll(32'hFFFF_FFFF, 8'h00);
        offer_poll(32'h0000_0013, 8'h00);
        for (n = 0; n < 7; n++) begin
            offer_poll(32'h0000_0014 + n, 8'h00);
        end

        // Switching the polarity while the pins read low: the stored raw levels are
        // kept, so every pressed button now reads as released. With zero windows the
        // long press is queued in the same poll as the press.
        drain();
        set_config(16'd0, 16'd0, 1'b0);
        write_reg(CFG_UNUSED_IDX, 16'hFFFF);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        offer_poll(32'd100, 8'h00);
        for (n = 0; n < 8; n++) begin
            offer_poll(32'd101 + n, 8'h55);
        end

        // Random phases, each under its own settings; the first two use the extremes.
        for (p = 0; p < NUM_PHASES; p++) begin
            drain();
            case (p)
                0: set_config(16'd0, 16'd0, 1'b0);
                1: set_config(16'hFFFF, 16'hFFFF, 1'b1);
                default: set_config(CFG_DATA_W'($urandom_range(0, 40)),
                                    CFG_DATA_W'($urandom_range(0, 300)),
                                    1'($urandom_range(0, 1)));
            endcase
            quiet    = (p == NUM_PHASES - 1);
            clock_ms = TIME_W'($urandom);
            for (n = 0; n < PHASE_POLLS; n++) begin
                // The receiver holds off once while polls keep coming, and once the
                // sender stops until everything has been delivered.
                if (p == 3 && n == 20) begin
                    hold_req = 1'b1;
                end
                if (p == 4 && n == 30) begin
                    drain();
                end
                random_poll();
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        events_sb.flag_leftovers();
        if (events_sb.mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ multi_button_debounce_longpress.f @@
rtl/mbd_pkg.sv
rtl/mbd_intf.sv
rtl/multi_button_debounce_longpress.sv
rtl/mbd_checker.sv
verif/multi_button_debounce_longpress_tb.sv
